// ----- rtl/fc_pkg.sv -----
// Shared types and constants for the flash command controller.
`timescale 1ns / 1ps
`default_nettype none

package fc_pkg;

  localparam int unsigned WINDOW_BYTES = 65536;
  localparam int unsigned SECTOR_BYTES = 4096;

  localparam logic [15:0] ADDR_UNLOCK1 = 16'h5555;
  localparam logic [15:0] ADDR_UNLOCK2 = 16'h2AAA;

  localparam logic [7:0] CMD_ID_ON    = 8'h90;
  localparam logic [7:0] CMD_ID_OFF   = 8'hF0;
  localparam logic [7:0] CMD_ERASE    = 8'h80;
  localparam logic [7:0] CMD_PROGRAM  = 8'hA0;
  localparam logic [7:0] CMD_BANK     = 8'hB0;
  localparam logic [7:0] KEY_UNLOCK1  = 8'hAA;
  localparam logic [7:0] KEY_UNLOCK2  = 8'h55;
  localparam logic [7:0] CMD_CHIP_ER  = 8'h10;
  localparam logic [7:0] CMD_SECT_ER  = 8'h30;

  localparam logic [7:0] ID_MFR_64K   = 8'h32;
  localparam logic [7:0] ID_DEV_64K   = 8'h1B;
  localparam logic [7:0] ID_MFR_128K  = 8'h62;
  localparam logic [7:0] ID_DEV_128K  = 8'h13;

  localparam logic [7:0] ERASED_BYTE  = 8'hFF;

  localparam logic BUS_READ  = 1'b0;
  localparam logic BUS_WRITE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE          = 4'd0,
    ST_UNLOCK1       = 4'd1,
    ST_UNLOCK2       = 4'd2,
    ST_ERASE_CMD     = 4'd3,
    ST_ERASE_UNLOCK1 = 4'd4,
    ST_ERASE_UNLOCK2 = 4'd5,
    ST_PROGRAM       = 4'd6,
    ST_BANK          = 4'd7
  } seq_state_t;

  typedef enum logic [1:0] {
    ID_NONE = 2'd0,
    ID_MFR  = 2'd1,
    ID_DEV  = 2'd2
  } id_sel_t;

  // Datapath command issued by the sequencer for one accepted beat.
  typedef struct packed {
    logic    rd;
    id_sel_t id_sel;
    logic    we;
    logic    sweep_chip;
    logic    sweep_sector;
    logic    bank;
  } fc_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/fc_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module fc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 131072
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/fc_datapath.sv -----
// Store datapath: index mapping, erase sweep, RAM and read result register.
`timescale 1ns / 1ps
`default_nettype none

module fc_datapath #(
  parameter int unsigned TOTAL_BYTES = 131072
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire fc_pkg::fc_cmd_t cmd,
  input  wire logic [15:0]     address,
  input  wire logic [7:0]      write_data,
  output logic                 sweep_busy,
  output logic                 out_valid,
  output logic [7:0]           out_read_data
);

  localparam int unsigned AW = $clog2(TOTAL_BYTES);
  localparam int unsigned CW = $clog2(TOTAL_BYTES + 1);
  localparam bit SMALL_PART = (TOTAL_BYTES == fc_pkg::WINDOW_BYTES);

  logic [17:0]      idx_wide;
  logic [AW-1:0]    idx;
  logic             sweep_r, sweep_nxt;
  logic [AW-1:0]    sweep_addr_r, sweep_addr_nxt;
  logic [CW-1:0]    sweep_left_r, sweep_left_nxt;
  logic             rd_r;
  fc_pkg::id_sel_t  id_sel_r;
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  // Bank offset plus window offset, wrapped once into the store.
  always_comb begin
    idx_wide = {1'b0, cmd.bank, address};
    if (idx_wide >= 18'(TOTAL_BYTES)) begin
      idx_wide = idx_wide - 18'(TOTAL_BYTES);
    end
    idx = idx_wide[AW-1:0];
  end

  always_comb begin
    sweep_nxt      = sweep_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_left_nxt = sweep_left_r;
    if (sweep_r) begin
      sweep_addr_nxt = (sweep_addr_r == AW'(TOTAL_BYTES - 1)) ? '0 : sweep_addr_r + 1'b1;
      sweep_left_nxt = sweep_left_r - 1'b1;
      if (sweep_left_r == CW'(1)) begin
        sweep_nxt = 1'b0;
      end
    end else if (cmd.sweep_chip) begin
      sweep_nxt      = 1'b1;
      sweep_addr_nxt = '0;
      sweep_left_nxt = CW'(TOTAL_BYTES);
    end else if (cmd.sweep_sector) begin
      sweep_nxt      = 1'b1;
      sweep_addr_nxt = idx;
      sweep_left_nxt = CW'(fc_pkg::SECTOR_BYTES);
    end
  end

  // Reset starts a full clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r      <= 1'b1;
      sweep_addr_r <= '0;
      sweep_left_r <= CW'(TOTAL_BYTES);
      rd_r         <= 1'b0;
      id_sel_r     <= fc_pkg::ID_NONE;
    end else begin
      sweep_r      <= sweep_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_left_r <= sweep_left_nxt;
      rd_r         <= cmd.rd;
      id_sel_r     <= cmd.id_sel;
    end
  end

  always_comb begin
    ram_we    = sweep_r | cmd.we;
    ram_addr  = sweep_r ? sweep_addr_r : idx;
    ram_wdata = sweep_r ? fc_pkg::ERASED_BYTE : write_data;
  end

  fc_ram #(
    .WIDTH(8),
    .DEPTH(TOTAL_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_comb begin
    case (id_sel_r)
      fc_pkg::ID_MFR: out_read_data = SMALL_PART ? fc_pkg::ID_MFR_64K : fc_pkg::ID_MFR_128K;
      fc_pkg::ID_DEV: out_read_data = SMALL_PART ? fc_pkg::ID_DEV_64K : fc_pkg::ID_DEV_128K;
      default:        out_read_data = ram_rdata;
    endcase
  end

  assign out_valid  = rd_r;
  assign sweep_busy = sweep_r;

endmodule

`default_nettype wire

// ----- rtl/fc_controller.sv -----
// Command sequencer: unlock/command state machine, ID mode and bank select.
`timescale 1ns / 1ps
`default_nettype none

module fc_controller #(
  parameter int unsigned TOTAL_BYTES = 131072
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             sweep_busy,
  input  wire logic             in_command,
  input  wire logic [15:0]      in_address,
  input  wire logic [7:0]       in_write_data,
  output logic                  busy,
  output fc_pkg::fc_cmd_t       cmd
);

  localparam bit BANK_EN = (TOTAL_BYTES > fc_pkg::WINDOW_BYTES);

  fc_pkg::seq_state_t seq_r, seq_nxt;
  logic               ident_r, ident_nxt;
  logic               bank_r, bank_nxt;
  logic               accept;
  logic               sector_base;

  assign busy        = sweep_busy;
  assign accept      = start & ~sweep_busy;
  assign sector_base = (in_address & 16'(fc_pkg::SECTOR_BYTES - 1)) == 16'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= fc_pkg::ST_IDLE;
      ident_r <= 1'b0;
      bank_r  <= 1'b0;
    end else begin
      seq_r   <= seq_nxt;
      ident_r <= ident_nxt;
      bank_r  <= bank_nxt;
    end
  end

  always_comb begin
    seq_nxt          = seq_r;
    ident_nxt        = ident_r;
    bank_nxt         = bank_r;
    cmd              = '0;
    cmd.id_sel       = fc_pkg::ID_NONE;
    cmd.bank         = bank_r;
    if (accept && in_command == fc_pkg::BUS_READ) begin
      cmd.rd = 1'b1;
      if (ident_r && in_address == 16'd0) begin
        cmd.id_sel = fc_pkg::ID_MFR;
      end else if (ident_r && in_address == 16'd1) begin
        cmd.id_sel = fc_pkg::ID_DEV;
      end
    end else if (accept) begin
      if (seq_r == fc_pkg::ST_PROGRAM) begin
        cmd.we  = 1'b1;
        seq_nxt = fc_pkg::ST_IDLE;
      end else if (seq_r == fc_pkg::ST_BANK && BANK_EN && in_address == 16'd0) begin
        bank_nxt = in_write_data[0];
        seq_nxt  = fc_pkg::ST_IDLE;
      end else if (in_address == fc_pkg::ADDR_UNLOCK2) begin
        if (seq_r == fc_pkg::ST_UNLOCK1) begin
          if (in_write_data == fc_pkg::KEY_UNLOCK2) seq_nxt = fc_pkg::ST_UNLOCK2;
        end else if (seq_r == fc_pkg::ST_ERASE_UNLOCK1) begin
          if (in_write_data == fc_pkg::KEY_UNLOCK2) seq_nxt = fc_pkg::ST_ERASE_UNLOCK2;
        end else begin
          seq_nxt = fc_pkg::ST_IDLE;
        end
      end else if (in_address == fc_pkg::ADDR_UNLOCK1) begin
        unique case (seq_r)
          fc_pkg::ST_IDLE: begin
            if (in_write_data == fc_pkg::KEY_UNLOCK1) seq_nxt = fc_pkg::ST_UNLOCK1;
          end
          fc_pkg::ST_ERASE_CMD: begin
            if (in_write_data == fc_pkg::KEY_UNLOCK1) seq_nxt = fc_pkg::ST_ERASE_UNLOCK1;
          end
          fc_pkg::ST_UNLOCK2: begin
            unique case (in_write_data)
              fc_pkg::CMD_ID_ON: begin
                ident_nxt = 1'b1;
                seq_nxt   = fc_pkg::ST_IDLE;
              end
              fc_pkg::CMD_ID_OFF: begin
                ident_nxt = 1'b0;
                seq_nxt   = fc_pkg::ST_IDLE;
              end
              fc_pkg::CMD_ERASE:   seq_nxt = fc_pkg::ST_ERASE_CMD;
              fc_pkg::CMD_PROGRAM: seq_nxt = fc_pkg::ST_PROGRAM;
              fc_pkg::CMD_BANK:    seq_nxt = fc_pkg::ST_BANK;
              default:             seq_nxt = fc_pkg::ST_IDLE;
            endcase
          end
          fc_pkg::ST_ERASE_UNLOCK2: begin
            cmd.sweep_chip = (in_write_data == fc_pkg::CMD_CHIP_ER);
            seq_nxt        = fc_pkg::ST_IDLE;
          end
          default: seq_nxt = fc_pkg::ST_IDLE;
        endcase
      end else if (sector_base) begin
        // Drop anything but the sector erase key after a full erase unlock.
        if (in_write_data == fc_pkg::CMD_SECT_ER && seq_r == fc_pkg::ST_ERASE_UNLOCK2) begin
          cmd.sweep_sector = 1'b1;
          seq_nxt          = fc_pkg::ST_IDLE;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/flash_command_controller_core.sv -----
// Top level of the parallel flash command controller.
// Reads: read_data on out_valid the cycle after acceptance; one beat per cycle unless busy.
// Writes: no result, one beat per cycle unless busy; program writes RAM at the accepting edge.
// Sector erase clears one 4096-byte sector and chip erase the whole store with busy high,
// one store byte per cycle through the single RAM port.
// Reset clears control state and runs a clearing pass over the whole store with busy high.
// Results are shown for one cycle only; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module flash_command_controller_core #(
  parameter int unsigned TOTAL_BYTES = 131072
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_command,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_write_data,
  output logic             out_valid,
  output logic [7:0]       out_read_data
);

  fc_pkg::fc_cmd_t cmd;
  logic            sweep_busy;

  fc_controller #(
    .TOTAL_BYTES(TOTAL_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .sweep_busy   (sweep_busy),
    .in_command   (in_command),
    .in_address   (in_address),
    .in_write_data(in_write_data),
    .busy         (busy),
    .cmd          (cmd)
  );

  fc_datapath #(
    .TOTAL_BYTES(TOTAL_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .address      (in_address),
    .write_data   (in_write_data),
    .sweep_busy   (sweep_busy),
    .out_valid    (out_valid),
    .out_read_data(out_read_data)
  );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking bench for the flash command controller: directed table, then random beats and chip erases.
`timescale 1ns / 1ps
`default_nettype none

module tb;

  localparam int unsigned TOTAL_BYTES = 131072;
  localparam bit ONE_BANK = (TOTAL_BYTES == fc_pkg::WINDOW_BYTES);
  localparam int unsigned SECTOR_BUDGET = 24;

  typedef struct packed {
    logic        cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        pin;
    logic [7:0]  want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_command;
  logic [15:0] in_address;
  logic [7:0]  in_write_data;
  logic        out_valid;
  logic [7:0]  out_read_data;

  // shadow of the block's state
  fc_pkg::seq_state_t flash_seq;
  bit          id_on;
  bit          bank_sel;
  logic [7:0]  flash_mem [TOTAL_BYTES];

  logic [7:0]  read_expect_q [$];
  int          fail_count;
  int          beats_sent;
  int          idle_pct;
  int          sector_budget;
  bit          pin_en;
  logic [7:0]  pin_val;
  logic [15:0] addr_pool [16];
  dir_row_t    directed_rows [28];

  flash_command_controller_core #(
    .TOTAL_BYTES(TOTAL_BYTES)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_address   (in_address),
    .in_write_data(in_write_data),
    .out_valid    (out_valid),
    .out_read_data(out_read_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(12_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int unsigned flash_index(logic [15:0] off);
    return ((bank_sel ? fc_pkg::WINDOW_BYTES : 0) + off) % TOTAL_BYTES;
  endfunction

  task automatic flash_fill_erased();
    foreach (flash_mem[k]) flash_mem[k] = fc_pkg::ERASED_BYTE;
  endtask

  // Advance the shadow state by one accepted beat; reads return their byte.
  task automatic flash_apply_beat(input logic cmd, input logic [15:0] addr,
                                  input logic [7:0] data, output bit has_read,
                                  output logic [7:0] rd);
    int unsigned i;
    has_read = 1'b0;
    rd = '0;
    if (cmd == fc_pkg::BUS_READ) begin
      has_read = 1'b1;
      if (id_on && addr == 16'h0000) begin
        rd = ONE_BANK ? fc_pkg::ID_MFR_64K : fc_pkg::ID_MFR_128K;
      end else if (id_on && addr == 16'h0001) begin
        rd = ONE_BANK ? fc_pkg::ID_DEV_64K : fc_pkg::ID_DEV_128K;
      end else begin
        rd = flash_mem[flash_index(addr)];
      end
    end else if (flash_seq == fc_pkg::ST_PROGRAM) begin
      flash_mem[flash_index(addr)] = data;
      flash_seq = fc_pkg::ST_IDLE;
    end else if (flash_seq == fc_pkg::ST_BANK && !ONE_BANK && addr == 16'h0000) begin
      bank_sel = data[0];
      flash_seq = fc_pkg::ST_IDLE;
    end else if (addr == fc_pkg::ADDR_UNLOCK2) begin
      if (flash_seq == fc_pkg::ST_UNLOCK1) begin
        if (data == fc_pkg::KEY_UNLOCK2) flash_seq = fc_pkg::ST_UNLOCK2;
      end else if (flash_seq == fc_pkg::ST_ERASE_UNLOCK1) begin
        if (data == fc_pkg::KEY_UNLOCK2) flash_seq = fc_pkg::ST_ERASE_UNLOCK2;
      end else begin
        flash_seq = fc_pkg::ST_IDLE;
      end
    end else if (addr == fc_pkg::ADDR_UNLOCK1) begin
      case (flash_seq)
        fc_pkg::ST_IDLE: begin
          if (data == fc_pkg::KEY_UNLOCK1) flash_seq = fc_pkg::ST_UNLOCK1;
        end
        fc_pkg::ST_ERASE_CMD: begin
          if (data == fc_pkg::KEY_UNLOCK1) flash_seq = fc_pkg::ST_ERASE_UNLOCK1;
        end
        fc_pkg::ST_UNLOCK2: begin
          flash_seq = fc_pkg::ST_IDLE;
          case (data)
            fc_pkg::CMD_ID_ON:   id_on = 1'b1;
            fc_pkg::CMD_ID_OFF:  id_on = 1'b0;
            fc_pkg::CMD_ERASE:   flash_seq = fc_pkg::ST_ERASE_CMD;
            fc_pkg::CMD_PROGRAM: flash_seq = fc_pkg::ST_PROGRAM;
            fc_pkg::CMD_BANK:    flash_seq = fc_pkg::ST_BANK;
            default:             flash_seq = fc_pkg::ST_IDLE;
          endcase
        end
        fc_pkg::ST_ERASE_UNLOCK2: begin
          if (data == fc_pkg::CMD_CHIP_ER) flash_fill_erased();
          flash_seq = fc_pkg::ST_IDLE;
        end
        default: flash_seq = fc_pkg::ST_IDLE;
      endcase
    end else if ((addr % fc_pkg::SECTOR_BYTES) == 0) begin
      if (data == fc_pkg::CMD_SECT_ER && flash_seq == fc_pkg::ST_ERASE_UNLOCK2) begin
        for (i = 0; i < fc_pkg::SECTOR_BYTES; i++) begin
          flash_mem[flash_index(16'(addr + i))] = fc_pkg::ERASED_BYTE;
        end
        flash_seq = fc_pkg::ST_IDLE;
      end
    end
  endtask

  // Check results and track accepted beats at every rising edge.
  always @(posedge clk) begin
    bit got;
    logic [7:0] val;
    logic [7:0] want;
    if (rst_n) begin
      if (out_valid) begin
        if (read_expect_q.size() == 0) begin
          $error("out_read_data: no read pending, actual %02h", out_read_data);
          fail_count++;
        end else begin
          want = read_expect_q.pop_front();
          if (out_read_data !== want) begin
            $error("out_read_data: expected %02h, actual %02h", want, out_read_data);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        flash_apply_beat(in_command, in_address, in_write_data, got, val);
        if (got) read_expect_q.push_back(pin_en ? pin_val : val);
      end
    end
  end

  // Present one beat at the falling edge and hold it until the block takes it.
  task automatic drive_beat(input logic cmd, input logic [15:0] addr, input logic [7:0] data,
                            input bit pin = 1'b0, input logic [7:0] pin_data = '0);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      in_command <= 1'($urandom);
      in_address <= 16'($urandom);
      in_write_data <= 8'($urandom);
    end
    @(negedge clk);
    start <= 1'b1;
    in_command <= cmd;
    in_address <= addr;
    in_write_data <= data;
    pin_en = pin;
    pin_val = pin_data;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  function automatic logic [15:0] pick_addr();
    case ($urandom_range(9))
      0, 1, 2, 3: return addr_pool[$urandom_range(15)];
      4:          return {15'd0, 1'($urandom)};
      5:          return $urandom_range(1) ? fc_pkg::ADDR_UNLOCK1 : fc_pkg::ADDR_UNLOCK2;
      6:          return {4'($urandom), 12'h000};
      7:          return 16'hFFFF;
      default:    return 16'($urandom);
    endcase
  endfunction

  // Random byte that can never complete an erase.
  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == fc_pkg::CMD_CHIP_ER || b == fc_pkg::CMD_SECT_ER) b = b + 8'd1;
    return b;
  endfunction

  function automatic logic [7:0] any_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic unlock_cmd(input logic [7:0] code);
    drive_beat(fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, fc_pkg::KEY_UNLOCK1);
    drive_beat(fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK2, fc_pkg::KEY_UNLOCK2);
    drive_beat(fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, code);
  endtask

  task automatic erase_prefix();
    unlock_cmd(fc_pkg::CMD_ERASE);
    drive_beat(fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, fc_pkg::KEY_UNLOCK1);
    drive_beat(fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK2, fc_pkg::KEY_UNLOCK2);
  endtask

  task automatic random_episode();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 30) begin
      drive_beat(fc_pkg::BUS_READ, pick_addr(), 8'($urandom));
    end else if (pick < 50) begin
      unlock_cmd(fc_pkg::CMD_PROGRAM);
      drive_beat(fc_pkg::BUS_WRITE, pick_addr(), any_byte());
    end else if (pick < 58) begin
      unlock_cmd($urandom_range(1) ? fc_pkg::CMD_ID_ON : fc_pkg::CMD_ID_OFF);
    end else if (pick < 65) begin
      unlock_cmd(fc_pkg::CMD_BANK);
      drive_beat(fc_pkg::BUS_WRITE, ($urandom_range(4) != 0) ? 16'h0000 : pick_addr(),
                 8'($urandom));
    end else if (pick < 70) begin
      if (sector_budget > 0 && $urandom_range(9) < 7) begin
        erase_prefix();
        drive_beat(fc_pkg::BUS_WRITE, {4'($urandom), 12'h000}, fc_pkg::CMD_SECT_ER);
        sector_budget--;
      end else begin
        erase_prefix();
        if ($urandom_range(1)) drive_beat(fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, junk_byte());
        else drive_beat(fc_pkg::BUS_WRITE, {4'($urandom), 12'h000}, junk_byte());
      end
    end else if (pick < 85) begin
      // broken unlock: partial key, then a stray beat
      n = $urandom_range(2);
      if (n > 0) drive_beat(fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, fc_pkg::KEY_UNLOCK1);
      if (n > 1) drive_beat(fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK2, fc_pkg::KEY_UNLOCK2);
      case ($urandom_range(3))
        0:       drive_beat(fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, junk_byte());
        1:       drive_beat(fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK2, junk_byte());
        2:       drive_beat(fc_pkg::BUS_WRITE, pick_addr(), junk_byte());
        default: drive_beat(fc_pkg::BUS_READ, pick_addr(), 8'($urandom));
      endcase
    end else begin
      drive_beat(1'($urandom), 16'($urandom), junk_byte());
    end
  endtask

  task automatic random_beats(input int count);
    int target;
    target = beats_sent + count;
    while (beats_sent < target) random_episode();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_command = fc_pkg::BUS_READ;
    in_address = '0;
    in_write_data = '0;
    pin_en = 1'b0;
    pin_val = '0;
    idle_pct = 0;
    fail_count = 0;
    beats_sent = 0;
    sector_budget = SECTOR_BUDGET;
    flash_seq = fc_pkg::ST_IDLE;
    id_on = 1'b0;
    bank_sel = 1'b0;
    flash_fill_erased();
    foreach (addr_pool[k]) addr_pool[k] = 16'($urandom);

    directed_rows = '{
      '{fc_pkg::BUS_READ,  16'h0000, 8'h00, 1'b1, fc_pkg::ERASED_BYTE},
      '{fc_pkg::BUS_READ,  16'hFFFF, 8'hFF, 1'b1, fc_pkg::ERASED_BYTE},
      '{fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, fc_pkg::KEY_UNLOCK1, 1'b0, 8'h00},
      '{fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK2, fc_pkg::KEY_UNLOCK2, 1'b0, 8'h00},
      '{fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, fc_pkg::CMD_ID_ON,   1'b0, 8'h00},
      '{fc_pkg::BUS_READ,  16'h0000, 8'h00, 1'b1, fc_pkg::ID_MFR_128K},
      '{fc_pkg::BUS_READ,  16'h0001, 8'h00, 1'b1, fc_pkg::ID_DEV_128K},
      '{fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, fc_pkg::KEY_UNLOCK1, 1'b0, 8'h00},
      '{fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK2, fc_pkg::KEY_UNLOCK2, 1'b0, 8'h00},
      '{fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, fc_pkg::CMD_PROGRAM, 1'b0, 8'h00},
      '{fc_pkg::BUS_WRITE, 16'h0000, 8'h00, 1'b0, 8'h00},
      // ID mode still shadows offset 0
      '{fc_pkg::BUS_READ,  16'h0000, 8'h00, 1'b1, fc_pkg::ID_MFR_128K},
      '{fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, fc_pkg::KEY_UNLOCK1, 1'b0, 8'h00},
      '{fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK2, fc_pkg::KEY_UNLOCK2, 1'b0, 8'h00},
      '{fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, fc_pkg::CMD_ID_OFF,  1'b0, 8'h00},
      '{fc_pkg::BUS_READ,  16'h0000, 8'hFF, 1'b0, 8'h00},
      '{fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, fc_pkg::KEY_UNLOCK1, 1'b0, 8'h00},
      '{fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK2, fc_pkg::KEY_UNLOCK2, 1'b0, 8'h00},
      '{fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, fc_pkg::CMD_ERASE,   1'b0, 8'h00},
      '{fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, fc_pkg::KEY_UNLOCK1, 1'b0, 8'h00},
      '{fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK2, fc_pkg::KEY_UNLOCK2, 1'b0, 8'h00},
      '{fc_pkg::BUS_WRITE, 16'h0000, fc_pkg::CMD_SECT_ER, 1'b0, 8'h00},
      '{fc_pkg::BUS_READ,  16'h0000, 8'h00, 1'b1, fc_pkg::ERASED_BYTE},
      '{fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, fc_pkg::KEY_UNLOCK1, 1'b0, 8'h00},
      '{fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK2, fc_pkg::KEY_UNLOCK2, 1'b0, 8'h00},
      '{fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, fc_pkg::CMD_BANK,    1'b0, 8'h00},
      '{fc_pkg::BUS_WRITE, 16'h0000, 8'h01, 1'b0, 8'h00},
      '{fc_pkg::BUS_READ,  16'h0000, 8'h00, 1'b1, fc_pkg::ERASED_BYTE}
    };

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      drive_beat(directed_rows[k].cmd, directed_rows[k].addr, directed_rows[k].data,
                 directed_rows[k].pin, directed_rows[k].want);
    end

    idle_pct = 0;
    random_beats(500);
    erase_prefix();
    drive_beat(fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, fc_pkg::CMD_CHIP_ER);
    idle_pct = 64;
    random_beats(500);
    idle_pct = 38;
    random_beats(500);
    erase_prefix();
    drive_beat(fc_pkg::BUS_WRITE, fc_pkg::ADDR_UNLOCK1, fc_pkg::CMD_CHIP_ER);
    idle_pct = 0;
    random_beats(500);

    @(negedge clk);
    start <= 1'b0;
    while (read_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- flash_command_controller_core.f -----
rtl/fc_pkg.sv
rtl/fc_ram.sv
rtl/fc_datapath.sv
rtl/fc_controller.sv
rtl/flash_command_controller_core.sv
tb/tb.sv
